>>> sv/mbsp_pkg.sv
package mbsp_pkg;

   // Result queue sizing; one byte can cause at most two results
   localparam int QueueDepth = 4;
   localparam int PtrWidth   = $clog2(QueueDepth);
   localparam int CountWidth = $clog2(QueueDepth + 1);

   // Byte codes
   localparam logic [7:0] SYSEX_START  = 8'hF0;
   localparam logic [7:0] MTC_QF       = 8'hF1;
   localparam logic [7:0] SONG_POS     = 8'hF2;
   localparam logic [7:0] SONG_SEL     = 8'hF3;
   localparam logic [7:0] TUNE_REQUEST = 8'hF6;
   localparam logic [7:0] SYSEX_EOX    = 8'hF7;
   localparam logic [7:0] REALTIME_LO  = 8'hF8;
   localparam logic [7:0] KEEP_ALIVE   = 8'hFE;
   localparam logic [7:0] DEFAULT_RUN  = 8'h90;

   typedef enum logic [1:0] {
      PH_NEED_STATUS = 2'd0,
      PH_NEED_ONE    = 2'd1,
      PH_NEED_TWO    = 2'd2,
      PH_SYSEX       = 2'd3
   } phase_type;

   typedef enum logic [3:0] {
      KIND_NOTE_OFF     = 4'd0,
      KIND_NOTE_ON      = 4'd1,
      KIND_POLY_PRESS   = 4'd2,
      KIND_CONTROL      = 4'd3,
      KIND_PROGRAM      = 4'd4,
      KIND_CHAN_PRESS   = 4'd5,
      KIND_BEND         = 4'd6,
      KIND_MTC_QF       = 4'd7,
      KIND_SONG_POS     = 4'd8,
      KIND_SONG_SEL     = 4'd9,
      KIND_TUNE         = 4'd10,
      KIND_SYSEX_DATA   = 4'd11,
      KIND_SYSEX_END    = 4'd12,
      KIND_REALTIME     = 4'd13,
      KIND_KEEP_ALIVE   = 4'd14
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] status_byte;
      logic [3:0] channel;
      logic [6:0] data_first;
      logic [6:0] data_second;
      logic       ended_by_eox;
      logic       last;
   } result_type;

   // Results of one byte, handed from the parser to the result queue
   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } push_type;

   function automatic result_type make_result(kind_type kind, logic [7:0] st,
                                              logic [6:0] d1, logic [6:0] d2,
                                              logic eox);
      result_type r;
      r.kind         = kind;
      r.status_byte  = st;
      r.channel      = st[3:0];
      r.data_first   = d1;
      r.data_second  = d2;
      r.ended_by_eox = eox;
      r.last         = 1'b0;
      return r;
   endfunction

endpackage

>>> sv/mbsp_if.sv
interface mbsp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink (input valid, input in_byte, output ready);
endinterface

interface mbsp_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] kind;
   logic [7:0] status_byte;
   logic [3:0] channel;
   logic [6:0] data_first;
   logic [6:0] data_second;
   logic       ended_by_eox;
   logic       last;

   modport source (output valid, output kind, output status_byte, output channel,
                   output data_first, output data_second, output ended_by_eox,
                   output last, input ready);
   modport sink (input valid, input kind, input status_byte, input channel,
                 input data_first, input data_second, input ended_by_eox,
                 input last, output ready);
endinterface

>>> sv/midi_byte_stream_parser_top.sv
// MIDI byte stream parser with running status. Each transfer on req_chan
// carries one received MIDI byte; decoded messages leave on rsp_chan, at
// most two per byte (a status byte that closes a sysex gives a sysex end,
// and a tune request that does so gives the tune result after it), with
// last set on the final one. A byte is registered at its transfer and
// decoded when the result queue has room; its results are registered in
// the queue and presented from there. One byte per cycle is taken as
// long as the four-entry result queue has room for two more entries. The
// offline bit, written from csr_wr_data with csr_wr_en, suppresses all
// results while set and parsing continues; a change of the bit re-arms
// running status. Write it only while idle.
module midi_byte_stream_parser_top (
   input  logic       clock,
   input  logic       reset,
   mbsp_req_if.sink   req_chan,
   mbsp_rsp_if.source rsp_chan,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data
);
   import mbsp_pkg::*;

   logic       stage_valid_ff, stage_valid_in;
   logic [7:0] stage_byte_ff, stage_byte_in;
   logic       advance;
   logic       room;
   logic       accept;
   push_type   push;

   // Decode the staged byte only when the queue can take two results
   assign advance        = stage_valid_ff && room;
   assign req_chan.ready = !stage_valid_ff || advance;
   assign accept         = req_chan.valid && req_chan.ready;

   // Input stage: hold a byte until it is decoded
   always_comb begin
      stage_byte_in  = accept ? req_chan.in_byte : stage_byte_ff;
      stage_valid_in = accept || (stage_valid_ff && !advance);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stage_byte_ff <= stage_byte_in;
   end

   mbsp_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .item_valid  (advance),
      .item_byte   (stage_byte_ff),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .push        (push)
   );

   mbsp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .room     (room),
      .rsp_chan (rsp_chan)
   );

endmodule

>>> sv/mbsp_parser.sv
module mbsp_parser (
   input  logic               clock,
   input  logic               reset,
   input  logic               item_valid,
   input  logic [7:0]         item_byte,
   input  logic               csr_wr_en,
   input  logic               csr_wr_data,
   output mbsp_pkg::push_type push
);
   import mbsp_pkg::*;

   phase_type  phase_ff, phase_in;
   logic [7:0] cur_status_ff, cur_status_in;
   logic [7:0] run_status_ff, run_status_in;
   logic       run_allowed_ff, run_allowed_in;
   logic       held_ff, held_in;
   logic [6:0] held_data_ff, held_data_in;
   phase_type  saved_phase_ff, saved_phase_in;
   logic       saved_allowed_ff, saved_allowed_in;
   logic [7:0] saved_status_ff, saved_status_in;
   logic       offline_ff, offline_in;

   result_type res0, res1, tune_res;
   logic [1:0] res_count;
   logic [6:0] d1, d2;

   function automatic kind_type kind_of(logic [7:0] st, logic [6:0] second);
      kind_type k;
      case (st[7:4])
         4'h8:    k = KIND_NOTE_OFF;
         4'h9:    k = (second == 7'd0) ? KIND_NOTE_OFF : KIND_NOTE_ON;
         4'hA:    k = KIND_POLY_PRESS;
         4'hB:    k = KIND_CONTROL;
         4'hC:    k = KIND_PROGRAM;
         4'hD:    k = KIND_CHAN_PRESS;
         4'hE:    k = KIND_BEND;
         default: begin
            if (st == MTC_QF) k = KIND_MTC_QF;
            else if (st == SONG_POS) k = KIND_SONG_POS;
            else k = KIND_SONG_SEL;
         end
      endcase
      return k;
   endfunction

   // Decode one byte and work out the next parse state
   always_comb begin
      phase_in         = phase_ff;
      cur_status_in    = cur_status_ff;
      run_status_in    = run_status_ff;
      run_allowed_in   = run_allowed_ff;
      held_in          = held_ff;
      held_data_in     = held_data_ff;
      saved_phase_in   = saved_phase_ff;
      saved_allowed_in = saved_allowed_ff;
      saved_status_in  = saved_status_ff;
      offline_in       = offline_ff;
      res0             = '0;
      res1             = '0;
      res_count        = 2'd0;
      d1               = 7'd0;
      d2               = 7'd0;
      tune_res         = make_result(KIND_TUNE, TUNE_REQUEST, 7'd0, 7'd0, 1'b0);

      if (item_valid) begin
         if (item_byte >= REALTIME_LO) begin
            // Realtime: answer at once, parse state untouched
            res0 = make_result((item_byte == KEEP_ALIVE) ? KIND_KEEP_ALIVE
                               : KIND_REALTIME, item_byte, 7'd0, 7'd0, 1'b0);
            res_count = 2'd1;
         end else if (item_byte[7]) begin
            // Any status byte closes an open sysex first
            if (phase_ff == PH_SYSEX) begin
               res0 = make_result(KIND_SYSEX_END, SYSEX_START, 7'd0, 7'd0,
                                  item_byte == SYSEX_EOX);
               res_count = 2'd1;
            end
            held_in = 1'b0;
            if (item_byte == SYSEX_EOX) begin
               // Restore the state saved at sysex start
               phase_in       = saved_phase_ff;
               run_allowed_in = saved_allowed_ff;
               cur_status_in  = saved_status_ff;
               if (saved_phase_ff != PH_NEED_STATUS && !saved_allowed_ff) begin
                  phase_in = PH_NEED_STATUS;
               end
            end else if (item_byte[7:4] != 4'hF) begin
               // Channel status: arm running status
               cur_status_in  = item_byte;
               run_status_in  = item_byte;
               run_allowed_in = 1'b1;
               phase_in = (item_byte[7:5] == 3'b110) ? PH_NEED_ONE : PH_NEED_TWO;
            end else begin
               unique case (item_byte) inside
                  SYSEX_START: begin
                     saved_phase_in   = phase_ff;
                     saved_allowed_in = run_allowed_ff;
                     saved_status_in  = cur_status_ff;
                     phase_in         = PH_SYSEX;
                  end
                  MTC_QF, SONG_SEL: phase_in = PH_NEED_ONE;
                  SONG_POS:         phase_in = PH_NEED_TWO;
                  default: begin
                     phase_in = PH_NEED_STATUS;
                     if (item_byte == TUNE_REQUEST) begin
                        if (res_count == 2'd0) res0 = tune_res;
                        else res1 = tune_res;
                        res_count = res_count + 2'd1;
                     end
                  end
               endcase
               cur_status_in  = item_byte;
               run_allowed_in = 1'b0;
            end
         end else begin
            // Data byte
            case (phase_ff)
               PH_SYSEX: begin
                  res0 = make_result(KIND_SYSEX_DATA, SYSEX_START, item_byte[6:0],
                                     7'd0, 1'b0);
                  res_count = 2'd1;
               end
               PH_NEED_TWO: begin
                  if (!held_ff) begin
                     held_data_in = item_byte[6:0];
                     held_in      = 1'b1;
                  end else begin
                     d1        = held_data_ff;
                     d2        = item_byte[6:0];
                     res_count = 2'd1;
                  end
               end
               PH_NEED_ONE: begin
                  d1        = item_byte[6:0];
                  res_count = 2'd1;
               end
               default: ;
            endcase
            if (res_count != 2'd0 && phase_ff != PH_SYSEX) begin
               res0 = make_result(kind_of(cur_status_ff, d2), cur_status_ff, d1, d2,
                                  1'b0);
               held_in = 1'b0;
               if (!run_allowed_ff) phase_in = PH_NEED_STATUS;
            end
         end
      end

      // A change of the offline bit re-arms running status
      if (csr_wr_en && csr_wr_data != offline_ff) begin
         offline_in     = csr_wr_data;
         cur_status_in  = DEFAULT_RUN;
         run_status_in  = DEFAULT_RUN;
         run_allowed_in = 1'b1;
         held_in        = 1'b0;
         phase_in       = PH_NEED_STATUS;
      end
   end

   // Mark the final result and drop everything while offline
   always_comb begin
      push.first  = res0;
      push.second = res1;
      push.count  = offline_ff ? 2'd0 : res_count;
      if (res_count == 2'd2) push.second.last = 1'b1;
      else push.first.last = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_NEED_STATUS;
         cur_status_ff    <= DEFAULT_RUN;
         run_status_ff    <= DEFAULT_RUN;
         run_allowed_ff   <= 1'b1;
         held_ff          <= 1'b0;
         held_data_ff     <= 7'd0;
         saved_phase_ff   <= PH_NEED_STATUS;
         saved_allowed_ff <= 1'b0;
         saved_status_ff  <= 8'd0;
         offline_ff       <= 1'b0;
      end else begin
         phase_ff         <= phase_in;
         cur_status_ff    <= cur_status_in;
         run_status_ff    <= run_status_in;
         run_allowed_ff   <= run_allowed_in;
         held_ff          <= held_in;
         held_data_ff     <= held_data_in;
         saved_phase_ff   <= saved_phase_in;
         saved_allowed_ff <= saved_allowed_in;
         saved_status_ff  <= saved_status_in;
         offline_ff       <= offline_in;
      end
   end

endmodule

>>> sv/mbsp_queue.sv
module mbsp_queue (
   input  logic               clock,
   input  logic               reset,
   input  mbsp_pkg::push_type push,
   output logic               room,
   mbsp_rsp_if.source         rsp_chan
);
   import mbsp_pkg::*;

   result_type            mem_ff [QueueDepth];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in, wr_next_ptr;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic                  pop;
   result_type            head;

   assign pop         = rsp_chan.valid && rsp_chan.ready;
   assign wr_next_ptr = PtrWidth'(wr_ptr_ff + 1'b1);
   assign room        = (count_ff <= CountWidth'(QueueDepth - 2));

   // Advance pointers and fill level
   always_comb begin
      wr_ptr_in = PtrWidth'(wr_ptr_ff + PtrWidth'(push.count));
      rd_ptr_in = PtrWidth'(rd_ptr_ff + PtrWidth'(pop));
      count_in  = CountWidth'(count_ff + CountWidth'(push.count) - CountWidth'(pop));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store up to two results per cycle
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) mem_ff[wr_ptr_ff] <= push.first;
      if (push.count == 2'd2) mem_ff[wr_next_ptr] <= push.second;
   end

   // Present the oldest result
   assign head                  = mem_ff[rd_ptr_ff];
   assign rsp_chan.valid        = (count_ff != '0);
   assign rsp_chan.kind         = head.kind;
   assign rsp_chan.status_byte  = head.status_byte;
   assign rsp_chan.channel      = head.channel;
   assign rsp_chan.data_first   = head.data_first;
   assign rsp_chan.data_second  = head.data_second;
   assign rsp_chan.ended_by_eox = head.ended_by_eox;
   assign rsp_chan.last         = head.last;

endmodule

>>> tb/mbsp_checker.sv
`timescale 1ns / 100ps

module mbsp_checker (
   input  logic clock,
   input  logic reset,
   mbsp_req_if  req_chan,
   mbsp_rsp_if  rsp_chan,
   input  logic csr_wr_en,
   input  logic csr_wr_data,
   output int   fail_count,
   output int   pending,
   output int   msgs_checked
);
   import mbsp_pkg::*;

   // Status byte high nibbles
   localparam logic [3:0] NIB_NOTE_OFF   = 4'h8;
   localparam logic [3:0] NIB_NOTE_ON    = 4'h9;
   localparam logic [3:0] NIB_POLY_PRESS = 4'hA;
   localparam logic [3:0] NIB_CONTROL    = 4'hB;
   localparam logic [3:0] NIB_PROGRAM    = 4'hC;
   localparam logic [3:0] NIB_CHAN_PRESS = 4'hD;
   localparam logic [3:0] NIB_BEND       = 4'hE;
   localparam logic [3:0] NIB_SYSTEM     = 4'hF;

   // Parser state mirrored from the block
   logic       offline;
   phase_type  phase;
   phase_type  saved_phase;
   logic [7:0] cur_status;
   logic [7:0] saved_status;
   logic       running_ok;
   logic       saved_running_ok;
   logic [1:0] held_count;
   logic [6:0] held_data;

   // Messages decoded from one byte, then the queue of messages still owed
   result_type step_msgs [2];
   int         step_count;
   result_type due_messages [$];

   int mismatches;
   int compared;

   function automatic void rearm_running();
      cur_status = DEFAULT_RUN;
      running_ok = 1'b1;
      held_count = 2'd0;
      phase      = PH_NEED_STATUS;
   endfunction

   function automatic void post_message(kind_type k, logic [7:0] st, logic [6:0] d1,
                                        logic [6:0] d2, logic eox);
      result_type m;
      m.kind         = k;
      m.status_byte  = st;
      m.channel      = st[3:0];
      m.data_first   = d1;
      m.data_second  = d2;
      m.ended_by_eox = eox;
      m.last         = 1'b0;
      step_msgs[step_count] = m;
      step_count++;
   endfunction

   function automatic kind_type message_kind(logic [7:0] st, logic [6:0] d2);
      case (st[7:4])
         NIB_NOTE_OFF:   return KIND_NOTE_OFF;
         NIB_NOTE_ON:    return (d2 == 7'd0) ? KIND_NOTE_OFF : KIND_NOTE_ON;
         NIB_POLY_PRESS: return KIND_POLY_PRESS;
         NIB_CONTROL:    return KIND_CONTROL;
         NIB_PROGRAM:    return KIND_PROGRAM;
         NIB_CHAN_PRESS: return KIND_CHAN_PRESS;
         NIB_BEND:       return KIND_BEND;
         default: begin
            if (st == MTC_QF) return KIND_MTC_QF;
            if (st == SONG_POS) return KIND_SONG_POS;
            return KIND_SONG_SEL;
         end
      endcase
   endfunction

   function automatic void take_data(logic [6:0] d);
      logic       complete;
      logic [6:0] d1;
      logic [6:0] d2;
      complete = 1'b0;
      d1 = d;
      d2 = 7'd0;
      case (phase)
         PH_SYSEX: post_message(KIND_SYSEX_DATA, SYSEX_START, d, 7'd0, 1'b0);
         PH_NEED_TWO: begin
            if (held_count == 2'd0) begin
               held_data  = d;
               held_count = 2'd1;
            end else begin
               d1 = held_data;
               d2 = d;
               complete = 1'b1;
            end
         end
         PH_NEED_ONE: complete = 1'b1;
         default: ;
      endcase
      // Close the message; without running status wait for a new status
      if (complete) begin
         post_message(message_kind(cur_status, d2), cur_status, d1, d2, 1'b0);
         held_count = 2'd0;
         if (!running_ok) phase = PH_NEED_STATUS;
      end
   endfunction

   function automatic void take_status(logic [7:0] b);
      if (phase == PH_SYSEX)
         post_message(KIND_SYSEX_END, SYSEX_START, 7'd0, 7'd0, b == SYSEX_EOX);
      held_count = 2'd0;
      if (b == SYSEX_EOX) begin
         // Restore the state from before the sysex; drop a stale partial message
         phase      = saved_phase;
         running_ok = saved_running_ok;
         cur_status = saved_status;
         if (phase != PH_NEED_STATUS && !running_ok) phase = PH_NEED_STATUS;
      end else if (b[7:4] != NIB_SYSTEM) begin
         cur_status = b;
         running_ok = 1'b1;
         phase = (b[7:4] == NIB_PROGRAM || b[7:4] == NIB_CHAN_PRESS) ? PH_NEED_ONE
                 : PH_NEED_TWO;
      end else begin
         if (b == SYSEX_START) begin
            saved_phase      = phase;
            saved_running_ok = running_ok;
            saved_status     = cur_status;
            phase = PH_SYSEX;
         end else if (b == MTC_QF || b == SONG_SEL) begin
            phase = PH_NEED_ONE;
         end else if (b == SONG_POS) begin
            phase = PH_NEED_TWO;
         end else begin
            phase = PH_NEED_STATUS;
            if (b == TUNE_REQUEST) post_message(KIND_TUNE, b, 7'd0, 7'd0, 1'b0);
         end
         cur_status = b;
         running_ok = 1'b0;
      end
   endfunction

   function automatic void parse_midi_byte(logic [7:0] b);
      step_count = 0;
      if (b >= REALTIME_LO)
         post_message((b == KEEP_ALIVE) ? KIND_KEEP_ALIVE : KIND_REALTIME, b, 7'd0, 7'd0,
                      1'b0);
      else if (b[7])
         take_status(b);
      else
         take_data(b[6:0]);
      // Offline drops every message but keeps the parse going
      if (!offline && step_count > 0) begin
         step_msgs[step_count - 1].last = 1'b1;
         for (int i = 0; i < step_count; i++) due_messages.push_back(step_msgs[i]);
      end
   endfunction

   function automatic bit field_differs(string name, logic [7:0] want_v, logic [7:0] got_v);
      if (got_v !== want_v) begin
         $error("%s: expected %0h, actual %0h", name, want_v, got_v);
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic void check_message();
      result_type want;
      bit         bad;
      if (due_messages.size() == 0) begin
         $error("unexpected result: kind %0d, status_byte %0h", rsp_chan.kind,
                rsp_chan.status_byte);
         mismatches++;
      end else begin
         want = due_messages.pop_front();
         bad = 1'b0;
         bad |= field_differs("kind", 8'(want.kind), 8'(rsp_chan.kind));
         bad |= field_differs("status_byte", want.status_byte, rsp_chan.status_byte);
         bad |= field_differs("channel", 8'(want.channel), 8'(rsp_chan.channel));
         bad |= field_differs("data_first", 8'(want.data_first),
                              8'(rsp_chan.data_first));
         bad |= field_differs("data_second", 8'(want.data_second),
                              8'(rsp_chan.data_second));
         bad |= field_differs("ended_by_eox", 8'(want.ended_by_eox),
                              8'(rsp_chan.ended_by_eox));
         bad |= field_differs("last", 8'(want.last), 8'(rsp_chan.last));
         if (bad) mismatches++;
         compared++;
      end
   endfunction

   // Watch the channels: compare results, track the register, predict on each byte
   always @(posedge clock) begin
      if (reset) begin
         offline = 1'b0;
         rearm_running();
         held_data        = 7'd0;
         saved_phase      = PH_NEED_STATUS;
         saved_running_ok = 1'b0;
         saved_status     = 8'h00;
         due_messages.delete();
         mismatches = 0;
         compared   = 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) check_message();
         if (csr_wr_en && csr_wr_data != offline) begin
            offline = csr_wr_data;
            rearm_running();
         end
         if (req_chan.valid && req_chan.ready) parse_midi_byte(req_chan.in_byte);
      end
      pending      <= due_messages.size();
      fail_count   <= mismatches;
      msgs_checked <= compared;
   end

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps

module tb;
   import mbsp_pkg::*;

   localparam logic [3:0] FIRST_CHAN_NIB = 4'h8;
   localparam logic [3:0] LAST_CHAN_NIB  = 4'hE;
   localparam logic [3:0] PROGRAM_NIB    = 4'hC;
   localparam logic [3:0] BEND_NIB       = 4'hE;
   localparam logic [7:0] STATUS_LO      = 8'h80;
   localparam logic [7:0] UNDEF_COMMON_1 = 8'hF4;
   localparam logic [7:0] UNDEF_COMMON_2 = 8'hF5;
   localparam logic [7:0] TICK_UNDEF     = 8'hF9;
   localparam logic [7:0] REALTIME_UNDEF = 8'hFD;
   localparam logic [7:0] REALTIME_HI    = 8'hFF;
   localparam int         SettleCycles   = 6;
   localparam int         CycleLimit     = 200000;
   localparam int         OnlineBytes    = 130;
   localparam int         OfflineBytes   = 40;

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   logic csr_wr_data;

   int fail_count;
   int pending;
   int msgs_checked;
   int idle_pct = 9;
   int bytes_sent = 0;
   int offline_writes = 0;
   int cycle_count = 0;

   // Opening bytes: ignored data, running status, velocity zero, realtime inside a
   // message, sysex closed by EOX and by tune request, system common, undefined bytes
   logic [7:0] opening_bytes [0:29] = '{
      8'h00, DEFAULT_RUN, 8'h3C, 8'h7F, 8'h3C, 8'h00, {BEND_NIB, 4'hF}, 8'h01,
      REALTIME_LO, 8'h7F, {PROGRAM_NIB, 4'h5}, 8'h7F, KEEP_ALIVE, REALTIME_HI,
      SYSEX_START, 8'h11, SYSEX_EOX, 8'h22, SYSEX_START, 8'h33, TUNE_REQUEST,
      MTC_QF, 8'h7F, SONG_POS, 8'h01, 8'h02, UNDEF_COMMON_1, SYSEX_EOX,
      TICK_UNDEF, REALTIME_UNDEF
   };

   // Offline setting per random phase; repeats check that an unchanged write is harmless
   logic offline_plan [0:6] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0};

   mbsp_req_if req_chan ();
   mbsp_rsp_if rsp_chan ();

   midi_byte_stream_parser_top i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   mbsp_checker i_chk (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_chan),
      .rsp_chan     (rsp_chan),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .fail_count   (fail_count),
      .pending      (pending),
      .msgs_checked (msgs_checked)
   );

   always #1 clock = ~clock;

   // Stall the result side at random unless in a steady stretch
   always @(posedge clock) begin
      rsp_chan.ready <= (idle_pct == 0) || ($urandom_range(99) >= idle_pct);
   end

   // Bound the run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic send_byte(input logic [7:0] b);
      int gap;
      if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         gap = $urandom_range(4, 1);
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.in_byte <= b;
      do @(posedge clock); while (!req_chan.ready);
      bytes_sent++;
   endtask

   function automatic logic [6:0] pick_data();
      case ($urandom_range(9))
         0:       return 7'h00;
         1:       return 7'h7F;
         default: return 7'($urandom_range(127));
      endcase
   endfunction

   // Send data bytes, now and then with a realtime byte slipped in between
   task automatic send_data(input int count, input bit zero_last);
      logic [6:0] d;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(99) < 6) send_byte(8'($urandom_range(REALTIME_HI, REALTIME_LO)));
         d = (zero_last && i == count - 1) ? 7'h00 : pick_data();
         send_byte({1'b0, d});
      end
   endtask

   task automatic send_message();
      int         pick;
      int         reps;
      int         n;
      logic [7:0] st;
      pick = $urandom_range(99);
      if (pick < 45) begin
         // Channel message, sometimes leaning on running status
         st = {4'($urandom_range(LAST_CHAN_NIB, FIRST_CHAN_NIB)), 4'($urandom_range(15))};
         n = (st[7:4] == PROGRAM_NIB || st[7:4] == PROGRAM_NIB + 4'h1) ? 1 : 2;
         if ($urandom_range(3) != 0) send_byte(st);
         reps = $urandom_range(3);
         for (int i = 0; i <= reps; i++) send_data(n, $urandom_range(7) == 0);
      end else if (pick < 60) begin
         // Sysex, closed by EOX or cut short by another status
         send_byte(SYSEX_START);
         send_data($urandom_range(6), 1'b0);
         if ($urandom_range(9) < 7) send_byte(SYSEX_EOX);
         else send_byte(8'($urandom_range(TUNE_REQUEST, STATUS_LO)));
      end else if (pick < 75) begin
         case ($urandom_range(5))
            0: begin send_byte(MTC_QF); send_data(1, 1'b0); end
            1: begin send_byte(SONG_POS); send_data(2, 1'b0); end
            2: begin send_byte(SONG_SEL); send_data(1, 1'b0); end
            3: send_byte(TUNE_REQUEST);
            4: send_byte(UNDEF_COMMON_1);
            default: send_byte(UNDEF_COMMON_2);
         endcase
      end else if (pick < 85) begin
         send_byte(8'($urandom_range(REALTIME_HI, REALTIME_LO)));
      end else if (pick < 92) begin
         send_byte(SYSEX_EOX);
      end else begin
         send_byte(8'($urandom_range(255)));
      end
   endtask

   // Hold the sender until every owed result is back and the pipe has settled
   task automatic quiesce();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_offline(input logic v);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      offline_writes++;
   endtask

   initial begin
      int target;
      reset            <= 1'b1;
      csr_wr_en        <= 1'b0;
      csr_wr_data      <= 1'b0;
      req_chan.valid   <= 1'b0;
      req_chan.in_byte <= 8'h00;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (opening_bytes[i]) send_byte(opening_bytes[i]);

      // Random phases, one offline setting each; phase two runs without idling
      foreach (offline_plan[p]) begin
         quiesce();
         write_offline(offline_plan[p]);
         idle_pct = (p == 2) ? 0 : 9;
         target = bytes_sent + (offline_plan[p] ? OfflineBytes : OnlineBytes);
         while (bytes_sent < target) begin
            send_message();
            if (!offline_plan[p] && $urandom_range(99) < 3) quiesce();
         end
      end

      idle_pct = 9;
      quiesce();
      $display("Sent %0d MIDI bytes over %0d offline settings; %0d messages compared",
               bytes_sent, offline_writes, msgs_checked);
      if (fail_count == 0 && pending == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
